// ===== design/htok_pkg.sv =====
// Shared types and constants for the HTTP request tokenizer.
// Holds the byte codes, result codes and the result record; no dependencies.
package htok_pkg;

  localparam int unsigned CNT_W = 7;

  // Bytes the parser reacts to
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_TWO   = 8'h32;
  localparam logic [7:0] CHAR_THREE = 8'h33;
  localparam logic [7:0] CHAR_COLON = 8'h3a;

  // Byte roles
  localparam logic [2:0] ROLE_NONE    = 3'd0;
  localparam logic [2:0] ROLE_METHOD  = 3'd1;
  localparam logic [2:0] ROLE_PATH    = 3'd2;
  localparam logic [2:0] ROLE_VERSION = 3'd3;
  localparam logic [2:0] ROLE_KEY     = 3'd4;
  localparam logic [2:0] ROLE_VALUE   = 3'd5;

  // Request outcome
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_METHOD = 3'd1;
  localparam logic [2:0] ST_EMPTY_PATH = 3'd2;
  localparam logic [2:0] ST_BAD_VER    = 3'd3;
  localparam logic [2:0] ST_HDR_DROP   = 3'd4;

  // Method codes
  localparam logic [1:0] METH_NONE = 2'd0;
  localparam logic [1:0] METH_GET  = 2'd1;
  localparam logic [1:0] METH_HEAD = 2'd2;
  localparam logic [1:0] METH_POST = 2'd3;

  // Version codes
  localparam logic [2:0] VER_NONE = 3'd0;
  localparam logic [2:0] VER_1_0  = 3'd1;
  localparam logic [2:0] VER_1_1  = 3'd2;
  localparam logic [2:0] VER_2_0  = 3'd3;
  localparam logic [2:0] VER_3_0  = 3'd4;

  typedef struct packed {
    logic [7:0]       data;
    logic [2:0]       role;
    logic             token_start;
    logic             done_res;
    logic [2:0]       status;
    logic [1:0]       method_code;
    logic [2:0]       version_code;
    logic [CNT_W-1:0] header_total;
  } htok_result_t;

endpackage

// ===== design/http_request_tokenizer.sv =====
// Top level of the HTTP request tokenizer: input register, handshake, checks.
// Depends on htok_pkg and htok_parser.
//
//   channel | signals                                      | direction
//   in      | in_valid_i, in_ready_o, data_byte_i          | byte into the block
//   out     | out_valid_o, out_ready_i, data_out_o, role_o, | tagged byte out
//           | token_start_o, done_res_o, status_o,         |
//           | method_code_o, version_code_o, header_total_o |
//
// One byte per cycle sustained while the output is not stalled; a result passes
// through the input register, then the result register, before it can transfer
// out.
// The parser state advances in the same cycle the byte moves into the result register.
// A stalled output holds the result; the input register then holds one more byte.
// Reset returns the parser to method matching with no headers counted.
module http_request_tokenizer #(
  parameter int unsigned MAX_HEADERS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 data_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 data_out_o,
  output logic [2:0]                 role_o,
  output logic                       token_start_o,
  output logic                       done_res_o,
  output logic [2:0]                 status_o,
  output logic [1:0]                 method_code_o,
  output logic [2:0]                 version_code_o,
  output logic [htok_pkg::CNT_W-1:0] header_total_o
);

  logic                   s1_valid_q;
  logic [7:0]             s1_byte_q;
  logic                   out_valid_q;
  logic                   s1_adv;
  logic                   in_xfer;
  htok_pkg::htok_result_t res;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_byte_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
        s1_byte_q  <= data_byte_i;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  htok_parser #(
    .MAX_HEADERS(MAX_HEADERS)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_adv),
    .byte_i (s1_byte_q),
    .res_o  (res)
  );

  assign out_valid_o    = out_valid_q;
  assign data_out_o     = res.data;
  assign role_o         = res.role;
  assign token_start_o  = res.token_start;
  assign done_res_o     = res.done_res;
  assign status_o       = res.status;
  assign method_code_o  = res.method_code;
  assign version_code_o = res.version_code;
  assign header_total_o = res.header_total;

`ifndef SYNTH
  // a held byte must not be lost or changed while the output is blocked
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_byte_q))
    else $error("input register lost or changed a byte under stall");

  a_fail_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o && status_o != htok_pkg::ST_OK |-> header_total_o == '0)
    else $error("failed request reports a header count");

  a_total_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> header_total_o <= htok_pkg::CNT_W'(MAX_HEADERS))
    else $error("header count above its limit");

  a_start_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_start_o |-> role_o != htok_pkg::ROLE_NONE)
    else $error("token start on a byte without a role");
`endif

endmodule

// ===== design/htok_parser.sv =====
// Byte classifier: parser state, per-byte decode and the result register.
// Depends on htok_pkg for byte codes, result codes and htok_result_t.
module htok_parser #(
  parameter int unsigned MAX_HEADERS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  output htok_pkg::htok_result_t res_o
);

  typedef enum logic [2:0] {
    PH_METHOD, PH_SKIP1, PH_PATH, PH_SKIP2, PH_VERSION, PH_POSTVER, PH_HEADER, PH_BODY
  } phase_e;

  typedef struct packed {
    logic in_value;
    logic used;
    logic started;
    logic space;
  } line_flags_t;

  function automatic logic [2:0] method_len(input logic [1:0] m);
    case (m)
      htok_pkg::METH_GET:  method_len = 3'd3;
      htok_pkg::METH_HEAD: method_len = 3'd4;
      htok_pkg::METH_POST: method_len = 3'd4;
      default:             method_len = 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] method_char(input logic [1:0] m, input logic [2:0] p);
    case ({m, p})
      {htok_pkg::METH_GET,  3'd1}: method_char = "E";
      {htok_pkg::METH_GET,  3'd2}: method_char = "T";
      {htok_pkg::METH_HEAD, 3'd1}: method_char = "E";
      {htok_pkg::METH_HEAD, 3'd2}: method_char = "A";
      {htok_pkg::METH_HEAD, 3'd3}: method_char = "D";
      {htok_pkg::METH_POST, 3'd1}: method_char = "O";
      {htok_pkg::METH_POST, 3'd2}: method_char = "S";
      {htok_pkg::METH_POST, 3'd3}: method_char = "T";
      default:                     method_char = htok_pkg::CHAR_NUL;
    endcase
  endfunction

  function automatic logic [7:0] prefix_char(input logic [2:0] p);
    case (p)
      3'd0:    prefix_char = "H";
      3'd1:    prefix_char = "T";
      3'd2:    prefix_char = "T";
      3'd3:    prefix_char = "P";
      3'd4:    prefix_char = "/";
      default: prefix_char = htok_pkg::CHAR_NUL;
    endcase
  endfunction

  localparam logic [htok_pkg::CNT_W-1:0] MaxCnt = htok_pkg::CNT_W'(MAX_HEADERS);

  phase_e                      phase_q, phase_d;
  logic [2:0]                  pos_q, pos_d;
  logic [1:0]                  method_q, method_d;
  logic [2:0]                  version_q, version_d;
  logic [htok_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  line_flags_t                 flags_q, flags_d;
  logic                        fin_q, fin_d;
  htok_pkg::htok_result_t      res_q, res_d;

  logic [2:0]  role, status, vpos, vnew, pos_nx;
  logic        start, done, v_ok;
  logic [1:0]  meth_sel;
  line_flags_t fl;

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    method_d  = method_q;
    version_d = version_q;
    cnt_d     = cnt_q;
    flags_d   = flags_q;
    fin_d     = fin_q;
    role      = htok_pkg::ROLE_NONE;
    start     = 1'b0;
    done      = 1'b0;
    status    = htok_pkg::ST_OK;
    vpos      = pos_q;
    vnew      = version_q;
    v_ok      = 1'b0;
    pos_nx    = pos_q + 3'd1;
    meth_sel  = htok_pkg::METH_NONE;
    fl        = flags_q;

    if (fin_q) begin
      // failed request: ignore everything up to the terminator
    end else if (byte_i == htok_pkg::CHAR_NUL) begin
      done = 1'b1;
      case (phase_q)
        PH_METHOD:                      status = htok_pkg::ST_BAD_METHOD;
        PH_SKIP1:                       status = htok_pkg::ST_EMPTY_PATH;
        PH_PATH, PH_SKIP2, PH_VERSION:  status = htok_pkg::ST_BAD_VER;
        PH_HEADER: status = flags_q.in_value ? htok_pkg::ST_HDR_DROP : htok_pkg::ST_OK;
        default:                        status = htok_pkg::ST_OK;
      endcase
    end else begin
      case (phase_q)
        PH_METHOD: begin
          if (pos_q == 3'd0) begin
            if (byte_i == "G")      meth_sel = htok_pkg::METH_GET;
            else if (byte_i == "H") meth_sel = htok_pkg::METH_HEAD;
            else if (byte_i == "P") meth_sel = htok_pkg::METH_POST;
            if (meth_sel == htok_pkg::METH_NONE) begin
              fin_d  = 1'b1;
              done   = 1'b1;
              status = htok_pkg::ST_BAD_METHOD;
            end else begin
              method_d = meth_sel;
              role     = htok_pkg::ROLE_METHOD;
              start    = 1'b1;
              pos_d    = 3'd1;
            end
          end else if (pos_q >= method_len(method_q) ||
                       byte_i != method_char(method_q, pos_q)) begin
            fin_d  = 1'b1;
            done   = 1'b1;
            status = htok_pkg::ST_BAD_METHOD;
          end else begin
            role = htok_pkg::ROLE_METHOD;
            if (pos_nx >= method_len(method_q)) begin
              phase_d = PH_SKIP1;
              pos_d   = 3'd0;
            end else begin
              pos_d = pos_nx;
            end
          end
        end
        PH_SKIP1: begin
          if (byte_i != htok_pkg::CHAR_SP) begin
            phase_d = PH_PATH;
            role    = htok_pkg::ROLE_PATH;
            start   = 1'b1;
          end
        end
        PH_PATH: begin
          if (byte_i == htok_pkg::CHAR_SP) phase_d = PH_SKIP2;
          else role = htok_pkg::ROLE_PATH;
        end
        PH_SKIP2, PH_VERSION: begin
          if (phase_q == PH_VERSION || byte_i != htok_pkg::CHAR_SP) begin
            vpos    = (phase_q == PH_SKIP2) ? 3'd0 : pos_q;
            phase_d = PH_VERSION;
            if (vpos < 3'd5) begin
              v_ok = (byte_i == prefix_char(vpos));
            end else if (vpos == 3'd5) begin
              if (byte_i == htok_pkg::CHAR_ONE)        vnew = htok_pkg::VER_1_0;
              else if (byte_i == htok_pkg::CHAR_TWO)   vnew = htok_pkg::VER_2_0;
              else if (byte_i == htok_pkg::CHAR_THREE) vnew = htok_pkg::VER_3_0;
              else                                     vnew = htok_pkg::VER_NONE;
              version_d = vnew;
              v_ok      = (vnew != htok_pkg::VER_NONE);
            end else if (vpos == 3'd6) begin
              v_ok = (byte_i == htok_pkg::CHAR_DOT);
            end else begin
              // minor digit: only 1.x accepts a one
              if (byte_i == htok_pkg::CHAR_ONE && version_q == htok_pkg::VER_1_0)
                vnew = htok_pkg::VER_1_1;
              version_d = vnew;
              v_ok = (byte_i == htok_pkg::CHAR_ZERO) || (vnew == htok_pkg::VER_1_1);
            end
            if (!v_ok) begin
              fin_d  = 1'b1;
              done   = 1'b1;
              status = htok_pkg::ST_BAD_VER;
            end else begin
              role  = htok_pkg::ROLE_VERSION;
              start = (vpos == 3'd0);
              if (vpos == 3'd7) begin
                phase_d = PH_POSTVER;
                pos_d   = 3'd0;
              end else begin
                pos_d = vpos + 3'd1;
              end
            end
          end
        end
        PH_POSTVER, PH_HEADER: begin
          if (phase_q == PH_HEADER ||
              (byte_i != htok_pkg::CHAR_CR && byte_i != htok_pkg::CHAR_LF)) begin
            fl      = (phase_q == PH_POSTVER) ? '0 : flags_q;
            phase_d = PH_HEADER;
            flags_d = fl;
            if (byte_i == htok_pkg::CHAR_CR) begin
              // drop
            end else if (byte_i == htok_pkg::CHAR_LF) begin
              if (!fl.used) phase_d = PH_BODY;
              else if (fl.in_value && cnt_q < MaxCnt) cnt_d = cnt_q + 1'b1;
              flags_d = '0;
            end else begin
              flags_d.used = 1'b1;
              if (!fl.in_value) begin
                if (byte_i == htok_pkg::CHAR_COLON) begin
                  flags_d.in_value = 1'b1;
                end else begin
                  role  = htok_pkg::ROLE_KEY;
                  start = !fl.used;
                end
              end else if (!fl.started) begin
                if (byte_i != htok_pkg::CHAR_SP && byte_i != htok_pkg::CHAR_TAB) begin
                  flags_d.started = 1'b1;
                  role  = htok_pkg::ROLE_VALUE;
                  start = 1'b1;
                end
              end else if (byte_i == htok_pkg::CHAR_SP) begin
                // keep the first space of a run, drop the rest
                if (!fl.space) begin
                  role          = htok_pkg::ROLE_VALUE;
                  flags_d.space = 1'b1;
                end
              end else begin
                role          = htok_pkg::ROLE_VALUE;
                flags_d.space = 1'b0;
              end
            end
          end
        end
        PH_BODY: begin
        end
        default: begin
        end
      endcase
    end

    res_d.data         = byte_i;
    res_d.role         = role;
    res_d.token_start  = start;
    res_d.done_res     = done;
    res_d.status       = status;
    res_d.method_code  = (!fin_q && phase_d > PH_METHOD) ? method_d : htok_pkg::METH_NONE;
    res_d.version_code = (!fin_q && phase_d > PH_VERSION) ? version_d : htok_pkg::VER_NONE;
    res_d.header_total = (fin_q || (done && status != htok_pkg::ST_OK)) ? '0 : cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_METHOD;
      pos_q     <= '0;
      method_q  <= htok_pkg::METH_NONE;
      version_q <= htok_pkg::VER_NONE;
      cnt_q     <= '0;
      flags_q   <= '0;
      fin_q     <= 1'b0;
      res_q     <= '0;
    end else if (step_i) begin
      res_q <= res_d;
      if (byte_i == htok_pkg::CHAR_NUL) begin
        // terminator: start over for the next request
        phase_q   <= PH_METHOD;
        pos_q     <= '0;
        method_q  <= htok_pkg::METH_NONE;
        version_q <= htok_pkg::VER_NONE;
        cnt_q     <= '0;
        flags_q   <= '0;
        fin_q     <= 1'b0;
      end else begin
        phase_q   <= phase_d;
        pos_q     <= pos_d;
        method_q  <= method_d;
        version_q <= version_d;
        cnt_q     <= cnt_d;
        flags_q   <= flags_d;
        fin_q     <= fin_d;
      end
    end
  end

  assign res_o = res_q;

endmodule
